### rtl/lkv_pkg.sv
// ---------------------------------------------------------------------------
// lkv_pkg: shared types for the LRU key-value cache
// Request/response payloads, the cell-to-cell link and opcode constants.
// ---------------------------------------------------------------------------
package lkv_pkg;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic signed [31:0] MISS_VALUE = -32'sd1;
  localparam logic [4:0]         LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } rsp_t;

  // Contents handed from one cell to the next older one.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } link_t;

endpackage

### rtl/lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Result: a get result strobes on done, registered from the compare (LOOK) state.
// Requests: one at a time (accept, compare, chain shift); busy holds off a new start.
// Reset: sync rst empties the store and sets the entry limit to 16.
// ---------------------------------------------------------------------------
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  // result channel: one-cycle strobe, no backpressure
  output logic       done,
  output rsp_t       rsp,
  // entry limit register write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  // The cells form a recency-ordered chain: cell 0 is the most recent
  // entry, cell fill_count-1 the least recent. Valid entries always form a
  // prefix of the chain. Every update moves one entry to cell 0 and shifts
  // the younger ones down by one cell.
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    LOOK = 3'b010,
    MOVE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [4:0]          entry_limit;
  logic [CW-1:0]       fill_count;
  req_t                item;
  logic                hit_q;
  logic                full_q;
  logic signed [31:0]  hit_value_q;
  logic [MAX_ENTRIES-1:0] target_q;

  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [MAX_ENTRIES:0]   en_chain;
  link_t                  cell_q  [MAX_ENTRIES];
  link_t                  cell_in [MAX_ENTRIES];
  link_t                  head;

  logic                   any_hit;
  logic signed [31:0]     hit_value;
  logic [LW-1:0]          eff_limit;
  logic                   full;
  logic [MAX_ENTRIES-1:0] target;

  // Limit writes are taken only while idle, so a request in flight sees
  // one limit from compare to shift.
  assign cfg_ready = (state == IDLE);
  assign busy      = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_limit <= cfg_data;
    end
  end

  // Effective limit: zero acts as one, anything above capacity is capped.
  always_comb begin
    if (entry_limit == 5'd0) begin
      eff_limit = LW'(1);
    end else if (LW'(entry_limit) > LW'(MAX_ENTRIES)) begin
      eff_limit = LW'(MAX_ENTRIES);
    end else begin
      eff_limit = LW'(entry_limit);
    end
  end

  assign full = (LW'(fill_count) >= eff_limit);

  // Hit data: at most one cell matches, so an AND-OR merge is enough.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_value = hit_value | cell_q[i].value;
      end
    end
  end
  assign any_hit = |match_vec;

  // Target slot, one-hot: the matching cell on a hit, the first free cell
  // on a fill, the least recent cell on a replacement, none on a get miss.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (any_hit) begin
        target[i] = match_vec[i];
      end else if (item.opcode == OP_GET) begin
        target[i] = 1'b0;
      end else if (full) begin
        target[i] = (CW'(i) == fill_count - CW'(1));
      end else begin
        target[i] = (CW'(i) == fill_count);
      end
    end
  end

  // New contents of cell 0: a set writes its value, a get hit re-inserts
  // the entry it found.
  assign head = '{valid: 1'b1,
                  key:   item.lookup_key,
                  value: (item.opcode == OP_SET) ? item.store_value : hit_value_q};

  assign en_chain[MAX_ENTRIES] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_in[g] = head;
    end else begin : g_body
      assign cell_in[g] = cell_q[g-1];
    end

    lkv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .move     (state == MOVE),
      .target   (target_q[g]),
      .en_in    (en_chain[g+1]),
      .en_out   (en_chain[g]),
      .link_in  (cell_in[g]),
      .link_out (cell_q[g]),
      .cmp_key  (item.lookup_key),
      .match    (match_vec[g])
    );

    assign valid_vec[g] = cell_q[g].valid;
  end

  // Sequencer: accept, compare, shift.
  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (start) state_next = LOOK;
      end
      LOOK: state_next = MOVE;
      MOVE: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      done       <= 1'b0;
      fill_count <= '0;
    end else begin
      state <= state_next;
      done  <= (state == LOOK) && (item.opcode == OP_GET);
      // A set that misses with room left grows the store by one entry.
      if ((state == MOVE) && (item.opcode == OP_SET) && !hit_q && !full_q) begin
        fill_count <= fill_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == IDLE) && start) begin
      item <= req;
    end
    if (state == LOOK) begin
      hit_q          <= any_hit;
      full_q         <= full;
      hit_value_q    <= hit_value;
      target_q       <= target;
      rsp.hit        <= any_hit;
      rsp.read_value <= any_hit ? hit_value : MISS_VALUE;
    end
  end

`ifndef SYNTH
  // Valid cells always number exactly fill_count.
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == fill_count)
    else $error("fill_count differs from number of valid cells");

  // Keys stay unique, so at most one cell hits during the compare.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == LOOK) |-> $onehot0(match_vec))
    else $error("more than one cell matched the key");

  // A result strobe follows the compare cycle of a get.
  a_done_after_get: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == LOOK) && (item.opcode == OP_GET))
    else $error("result strobe without a get compare");

  // A move touches at most one target slot.
  a_target_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == MOVE) |-> $onehot0(target_q))
    else $error("more than one target slot");
`endif

endmodule

### rtl/lkv_cell.sv
// ---------------------------------------------------------------------------
// lkv_cell: one recency slot of the LRU chain
// Holds one entry, compares it to the broadcast key, and on a move takes
// the contents of its younger neighbor when the shift window covers it.
// ---------------------------------------------------------------------------
module lkv_cell
  import lkv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               move,
  input  logic               target,
  input  logic               en_in,
  output logic               en_out,
  input  link_t              link_in,
  output link_t              link_out,
  input  logic signed [31:0] cmp_key,
  output logic               match
);

  logic               valid;
  logic signed [31:0] key;
  logic signed [31:0] value;

  // Shift window: the target slot and every cell younger than it.
  assign en_out = en_in | target;
  assign match  = valid && (key == cmp_key);
  assign link_out = '{valid: valid, key: key, value: value};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (move && en_out) begin
      valid <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move && en_out) begin
      key   <= link_in.key;
      value <= link_in.value;
    end
  end

endmodule
